// ===== sv/rfse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rfse_pkg;

  // Store geometry.
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Fixed field widths.
  localparam int CFG_W   = 9;
  localparam int COORD_W = 10;
  localparam int PIXEL_W = 32;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(256);

  typedef enum logic [2:0] {
    OP_PUT    = 3'd0,
    OP_GET    = 3'd1,
    OP_FILL   = 3'd2,
    OP_SCROLL = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    REG_DISPLAY_WIDTH  = 2'd0,
    REG_DISPLAY_HEIGHT = 2'd1,
    REG_ROW_STRIDE     = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_GET,
    CMD_PAINT,
    CMD_SCROLL
  } cmd_kind_e;

  // One classified command as it travels from the front to the back.
  typedef struct packed {
    cmd_kind_e          kind;
    logic [PIXEL_W-1:0] color;
    logic [CFG_W-1:0]   stride;
    logic [ADDR_W-1:0]  addr;        // get address or copy source base
    logic [ADDR_W-1:0]  paint_base;  // word address of the first painted row
    logic [CFG_W-1:0]   rows;        // painted rows, at least one when painting
    logic [CFG_W-1:0]   col_lo;      // first painted column
    logic [CFG_W-1:0]   cols;        // painted columns, at least one when painting
    logic [CFG_W-1:0]   copy_rows;   // rows moved by a scroll
    logic               paint_en;    // a scroll also paints its bottom band
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_START,
    BK_PAINT,
    BK_COPY,
    BK_COPY_END,
    BK_GET_RD,
    BK_GET_OUT
  } back_state_e;

endpackage

`default_nettype wire

// ===== sv/rfse_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rfse_front
  import rfse_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [PDATA_W-1:0] pwdata_i,
  output logic [PDATA_W-1:0] prdata_o,
  input  logic               start_i,
  input  logic               queue_full_i,
  input  logic [2:0]         operation_i,
  input  logic [COORD_W-1:0] x_pos_i,
  input  logic [COORD_W-1:0] y_pos_i,
  input  logic [COORD_W-1:0] rect_width_i,
  input  logic [COORD_W-1:0] rect_height_i,
  input  logic [PIXEL_W-1:0] color_i,
  input  logic [COORD_W-1:0] scroll_rows_i,
  input  logic [COORD_W-1:0] band_rows_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  logic [CFG_W-1:0] width_q, width_d;
  logic [CFG_W-1:0] height_q, height_d;
  logic [CFG_W-1:0] stride_q, stride_d;
  logic             cfg_we;
  reg_idx_e         cfg_idx;

  logic [COORD_W-1:0]       opa;
  logic [COORD_W+CFG_W-1:0] mul_a;
  logic [CFG_W-1:0]         band_top;
  logic [2*CFG_W-1:0]       mul_b;
  logic                     x_in, y_in;
  logic [COORD_W:0]         x_end, y_end;
  logic [CFG_W-1:0]         col_hi, row_hi;
  logic                     fill_any;
  logic                     big_scroll;
  logic                     screen_any;
  logic [CFG_W-1:0]         band_n;

  assign cfg_we  = psel_i && penable_i && pwrite_i;
  assign cfg_idx = reg_idx_e'(paddr_i[PADDR_W-1:2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    stride_d = stride_q;
    if (cfg_we) begin
      case (cfg_idx)
        REG_DISPLAY_WIDTH:  width_d  = pwdata_i[CFG_W-1:0];
        REG_DISPLAY_HEIGHT: height_d = pwdata_i[CFG_W-1:0];
        REG_ROW_STRIDE:     stride_d = pwdata_i[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_RESET;
      height_q <= CFG_RESET;
      stride_q <= CFG_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      stride_q <= stride_d;
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DISPLAY_WIDTH:  prdata_o = PDATA_W'(width_q);
      REG_DISPLAY_HEIGHT: prdata_o = PDATA_W'(height_q);
      REG_ROW_STRIDE:     prdata_o = PDATA_W'(stride_q);
      default:            prdata_o = '0;
    endcase
  end

  // Clipping against the display.
  assign x_in   = x_pos_i < COORD_W'(width_q);
  assign y_in   = y_pos_i < COORD_W'(height_q);
  assign x_end  = (COORD_W+1)'(x_pos_i) + (COORD_W+1)'(rect_width_i);
  assign y_end  = (COORD_W+1)'(y_pos_i) + (COORD_W+1)'(rect_height_i);
  assign col_hi = (x_end < (COORD_W+1)'(width_q)) ? x_end[CFG_W-1:0] : width_q;
  assign row_hi = (y_end < (COORD_W+1)'(height_q)) ? y_end[CFG_W-1:0] : height_q;
  assign fill_any = x_in && y_in && (rect_width_i != '0) && (rect_height_i != '0);

  assign big_scroll = scroll_rows_i >= COORD_W'(height_q);
  assign screen_any = (width_q != '0) && (height_q != '0);
  assign band_top   = (band_rows_i > COORD_W'(height_q)) ? '0 :
                      height_q - band_rows_i[CFG_W-1:0];
  assign band_n     = height_q - band_top;

  // Two small multipliers: the start row (or scroll source) base, and the band base.
  assign opa   = (operation_i == OP_SCROLL) ? scroll_rows_i : y_pos_i;
  assign mul_a = (COORD_W+CFG_W)'(opa) * (COORD_W+CFG_W)'(stride_q);
  assign mul_b = (2*CFG_W)'(band_top) * (2*CFG_W)'(stride_q);

  assign push_o = start_i && !queue_full_i;

  always_comb begin
    cmd_o            = '0;
    cmd_o.kind       = CMD_NONE;
    cmd_o.color      = color_i;
    cmd_o.stride     = stride_q;
    cmd_o.addr       = ADDR_W'(mul_a);
    cmd_o.paint_base = ADDR_W'(mul_a);
    cmd_o.rows       = CFG_W'(1);
    cmd_o.col_lo     = x_pos_i[CFG_W-1:0];
    cmd_o.cols       = CFG_W'(1);
    cmd_o.copy_rows  = height_q - scroll_rows_i[CFG_W-1:0];
    cmd_o.paint_en   = 1'b1;
    case (operation_i)
      OP_PUT: begin
        if (x_in && y_in) begin
          cmd_o.kind = CMD_PAINT;
        end
      end
      OP_GET: begin
        if (x_in && y_in) begin
          cmd_o.kind = CMD_GET;
          cmd_o.addr = ADDR_W'(mul_a) + ADDR_W'(x_pos_i);
        end
      end
      OP_FILL: begin
        if (fill_any) begin
          cmd_o.kind = CMD_PAINT;
          cmd_o.rows = row_hi - y_pos_i[CFG_W-1:0];
          cmd_o.cols = col_hi - x_pos_i[CFG_W-1:0];
        end
      end
      OP_SCROLL, OP_CLEAR: begin
        if ((operation_i == OP_CLEAR) || big_scroll) begin
          if (screen_any) begin
            cmd_o.kind       = CMD_PAINT;
            cmd_o.paint_base = '0;
            cmd_o.rows       = height_q;
            cmd_o.col_lo     = '0;
            cmd_o.cols       = width_q;
          end
        end else begin
          cmd_o.kind       = CMD_SCROLL;
          cmd_o.paint_base = ADDR_W'(mul_b);
          cmd_o.rows       = band_n;
          cmd_o.col_lo     = '0;
          cmd_o.cols       = width_q;
          cmd_o.paint_en   = (band_n != '0) && (width_q != '0);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/rfse_cmd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rfse_cmd_queue
  import rfse_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o,
  output logic full_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rfse_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rfse_back
  import rfse_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               read_valid_o,
  output logic [PIXEL_W-1:0] read_pixel_o
);

  back_state_e state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic [ADDR_W-1:0]  ptr_a_q, ptr_a_d;
  logic [ADDR_W-1:0]  ptr_b_q, ptr_b_d;
  logic [CFG_W-1:0]   rows_left_q, rows_left_d;
  logic [CFG_W-1:0]   col_q, col_d;
  logic               pend_q, pend_d;
  logic               res_valid_q, res_valid_d;
  logic [PIXEL_W-1:0] res_pixel_q, res_pixel_d;

  logic [PIXEL_W-1:0] mem_q [STORE_DEPTH];
  logic [PIXEL_W-1:0] rdata_q;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [PIXEL_W-1:0] mem_wdata;

  logic [ADDR_W-1:0] paint_addr;
  logic              paint_col_last;
  logic              copy_col_last;

  assign paint_addr     = ptr_a_q + ADDR_W'(cmd_q.col_lo) + ADDR_W'(col_q);
  assign paint_col_last = (col_q == cmd_q.cols - CFG_W'(1));
  assign copy_col_last  = (col_q == cmd_q.stride - CFG_W'(1));

  assign read_valid_o = res_valid_q;
  assign read_pixel_o = res_pixel_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    ptr_a_d     = ptr_a_q;
    ptr_b_d     = ptr_b_q;
    rows_left_d = rows_left_q;
    col_d       = col_q;
    pend_d      = pend_q;
    res_valid_d = 1'b0;
    res_pixel_d = res_pixel_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = ptr_b_q - ADDR_W'(1);
    mem_wdata   = rdata_q;
    mem_raddr   = ptr_a_q;
    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          state_d = BK_START;
        end
      end
      BK_START: begin
        pend_d = 1'b0;
        col_d  = '0;
        case (cmd_q.kind)
          CMD_GET: state_d = BK_GET_RD;
          CMD_PAINT: begin
            ptr_a_d     = cmd_q.paint_base;
            rows_left_d = cmd_q.rows;
            state_d     = BK_PAINT;
          end
          CMD_SCROLL: begin
            if (cmd_q.stride != '0) begin
              ptr_a_d     = cmd_q.addr;
              ptr_b_d     = '0;
              rows_left_d = cmd_q.copy_rows;
              state_d     = BK_COPY;
            end else if (cmd_q.paint_en) begin
              ptr_a_d     = cmd_q.paint_base;
              rows_left_d = cmd_q.rows;
              state_d     = BK_PAINT;
            end else begin
              res_valid_d = 1'b1;
              res_pixel_d = '0;
              state_d     = BK_IDLE;
            end
          end
          default: begin
            res_valid_d = 1'b1;
            res_pixel_d = '0;
            state_d     = BK_IDLE;
          end
        endcase
      end
      BK_PAINT: begin
        mem_we    = 1'b1;
        mem_waddr = paint_addr;
        mem_wdata = cmd_q.color;
        if (paint_col_last) begin
          col_d       = '0;
          ptr_a_d     = ptr_a_q + ADDR_W'(cmd_q.stride);
          rows_left_d = rows_left_q - CFG_W'(1);
          if (rows_left_q == CFG_W'(1)) begin
            res_valid_d = 1'b1;
            res_pixel_d = '0;
            state_d     = BK_IDLE;
          end
        end else begin
          col_d = col_q + CFG_W'(1);
        end
      end
      BK_COPY: begin
        // Read the source word of this step; write the word read one step earlier.
        mem_we  = pend_q;
        pend_d  = 1'b1;
        ptr_a_d = ptr_a_q + ADDR_W'(1);
        ptr_b_d = ptr_b_q + ADDR_W'(1);
        if (copy_col_last) begin
          col_d       = '0;
          rows_left_d = rows_left_q - CFG_W'(1);
          if (rows_left_q == CFG_W'(1)) begin
            state_d = BK_COPY_END;
          end
        end else begin
          col_d = col_q + CFG_W'(1);
        end
      end
      BK_COPY_END: begin
        mem_we = 1'b1;
        pend_d = 1'b0;
        if (cmd_q.paint_en) begin
          ptr_a_d     = cmd_q.paint_base;
          rows_left_d = cmd_q.rows;
          col_d       = '0;
          state_d     = BK_PAINT;
        end else begin
          res_valid_d = 1'b1;
          res_pixel_d = '0;
          state_d     = BK_IDLE;
        end
      end
      BK_GET_RD: begin
        mem_raddr = cmd_q.addr;
        state_d   = BK_GET_OUT;
      end
      BK_GET_OUT: begin
        res_valid_d = 1'b1;
        res_pixel_d = rdata_q;
        state_d     = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    ptr_a_q     <= ptr_a_d;
    ptr_b_q     <= ptr_b_d;
    rows_left_q <= rows_left_d;
    col_q       <= col_d;
    res_pixel_q <= res_pixel_d;
  end

  // Pixel store. A read that hits the word written in the same cycle sees the new value.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_we && (mem_waddr == mem_raddr)) begin
      rdata_q <= mem_wdata;
    end else begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/raster_fill_scroll_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Raster fill and scroll engine over a 65536-word pixel store (row * stride + column).
//
// Commands enter on start/busy: a command word is taken at a rising edge where start
// is high and busy is low. Each command gives exactly one result word on read_pixel_o,
// marked by read_valid_o for a single cycle; the receiver cannot hold results off.
// Only a get that lands inside the display returns a pixel, every other result is 0.
//
// The front classifies and clips each command at once and pushes it into a two-entry
// queue, so busy only rises when two commands are waiting behind the one in progress.
// The back executes one command at a time, bounded by the single store write port:
//   get: reads one word; put: writes one word; empty or discarded command: no access
//   fill or clear: writes rows * columns words
//   scroll: copies moved rows * row_stride words, then paints band rows * display_width
//   words (nothing is moved when row_stride is 0)
// A full-screen clear at the default 256 x 256 geometry writes all 65536 words.
//
// The display_width, display_height and row_stride registers sit on the APB port at
// byte addresses 0, 4 and 8; they reset to 256. The user must change them only while
// idle; the block does not enforce this. Reset clears the queue, the sequencer and the
// result strobe; the pixel store is not cleared and holds unknown data until written.

module raster_fill_scroll_engine
  import rfse_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation_i,
  input  logic [COORD_W-1:0] x_pos_i,
  input  logic [COORD_W-1:0] y_pos_i,
  input  logic [COORD_W-1:0] rect_width_i,
  input  logic [COORD_W-1:0] rect_height_i,
  input  logic [PIXEL_W-1:0] color_i,
  input  logic [COORD_W-1:0] scroll_rows_i,
  input  logic [COORD_W-1:0] band_rows_i,
  output logic               read_valid_o,
  output logic [PIXEL_W-1:0] read_pixel_o
);

  logic push;
  logic pop;
  logic queue_full;
  logic queue_empty;
  cmd_t front_cmd;
  cmd_t head_cmd;

  // Register accesses complete without wait states.
  assign pready = 1'b1;
  assign busy   = queue_full;

  rfse_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .prdata_o      (prdata),
    .start_i       (start),
    .queue_full_i  (queue_full),
    .operation_i   (operation_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .color_i       (color_i),
    .scroll_rows_i (scroll_rows_i),
    .band_rows_i   (band_rows_i),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  rfse_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (queue_empty),
    .full_o  (queue_full)
  );

  rfse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (head_cmd),
    .empty_i      (queue_empty),
    .pop_o        (pop),
    .read_valid_o (read_valid_o),
    .read_pixel_o (read_pixel_o)
  );

endmodule

`default_nettype wire

// ===== sv/rfse_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rfse_checker
  import rfse_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [PDATA_W-1:0] pwdata,
  input logic [PDATA_W-1:0] prdata,
  input logic               start,
  input logic               busy,
  input logic               read_valid_o
);

  // Every command passes through the pop and dispatch states before its result, so strobes never touch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_valid_o |=> !read_valid_o)
    else $error("result strobes in consecutive cycles");

  // The queue only fills up through an accepted command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted command");

  // Leaving reset, nothing is queued and no result is pending.
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (!busy && !read_valid_o))
    else $error("state not clear after reset");

  // A written row stride reads back on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_ROW_STRIDE)) |=>
    ((paddr[PADDR_W-1:2] != REG_ROW_STRIDE) ||
     (prdata == PDATA_W'($past(pwdata[CFG_W-1:0])))))
    else $error("row stride read back mismatch");

endmodule

bind raster_fill_scroll_engine rfse_checker u_checker (.*);

`default_nettype wire

// ===== tb/tb_raster_fill_scroll_engine.sv =====
`timescale 1ns / 1ps

// Scoreboard for the raster engine. It keeps its own copy of the pixel store and of the
// display geometry. It works out the result word of every accepted command and checks
// the result words that the block returns, in order.
class raster_scoreboard;

  bit [rfse_pkg::PIXEL_W-1:0] store [rfse_pkg::STORE_DEPTH];
  int unsigned                disp_w;
  int unsigned                disp_h;
  int unsigned                stride;
  bit [rfse_pkg::PIXEL_W-1:0] expected_pixels [$];
  int unsigned                errors;
  int unsigned                checked;

  function new();
    disp_w  = rfse_pkg::CFG_RESET;
    disp_h  = rfse_pkg::CFG_RESET;
    stride  = rfse_pkg::CFG_RESET;
    errors  = 0;
    checked = 0;
  endfunction

  function void set_register(rfse_pkg::reg_idx_e idx, bit [rfse_pkg::CFG_W-1:0] value);
    case (idx)
      rfse_pkg::REG_DISPLAY_WIDTH:  disp_w = value;
      rfse_pkg::REG_DISPLAY_HEIGHT: disp_h = value;
      rfse_pkg::REG_ROW_STRIDE:     stride = value;
      default: ;
    endcase
  endfunction

  function int unsigned word_addr(int unsigned row, int unsigned col);
    return (row * stride + col) % rfse_pkg::STORE_DEPTH;
  endfunction

  // Writes a rectangle, clipped against the display.
  function void paint(int unsigned top, int unsigned rows, int unsigned left,
                      int unsigned cols, bit [rfse_pkg::PIXEL_W-1:0] value);
    for (int unsigned r = top; r < top + rows && r < disp_h; r++)
      for (int unsigned c = left; c < left + cols && c < disp_w; c++)
        store[word_addr(r, c)] = value;
  endfunction

  function void move_rows_up(int unsigned count, int unsigned band,
                             bit [rfse_pkg::PIXEL_W-1:0] value);
    int unsigned words;
    int unsigned base;
    int unsigned top;
    if (count >= disp_h) begin
      paint(0, disp_h, 0, disp_w, value);
      return;
    end
    words = (disp_h - count) * stride;
    base  = count * stride;
    // Ascending copy, so overlapping source and target behave like the block.
    for (int unsigned i = 0; i < words; i++)
      store[i % rfse_pkg::STORE_DEPTH] = store[(base + i) % rfse_pkg::STORE_DEPTH];
    top = (band > disp_h) ? 0 : disp_h - band;
    paint(top, band, 0, disp_w, value);
  endfunction

  function void note_command(logic [2:0] op, int unsigned x, int unsigned y,
                             int unsigned rect_w, int unsigned rect_h,
                             bit [rfse_pkg::PIXEL_W-1:0] color,
                             int unsigned count, int unsigned band);
    bit [rfse_pkg::PIXEL_W-1:0] pixel;
    bit                         on_screen;
    pixel     = '0;
    on_screen = (x < disp_w) && (y < disp_h);
    case (op)
      rfse_pkg::OP_PUT:    if (on_screen) store[word_addr(y, x)] = color;
      rfse_pkg::OP_GET:    if (on_screen) pixel = store[word_addr(y, x)];
      rfse_pkg::OP_FILL:   paint(y, rect_h, x, rect_w, color);
      rfse_pkg::OP_SCROLL: move_rows_up(count, band, color);
      rfse_pkg::OP_CLEAR:  paint(0, disp_h, 0, disp_w, color);
      default: ;
    endcase
    expected_pixels.push_back(pixel);
  endfunction

  function void check_pixel(bit [rfse_pkg::PIXEL_W-1:0] actual);
    bit [rfse_pkg::PIXEL_W-1:0] want;
    if (expected_pixels.size() == 0) begin
      $error("read_pixel: result word with no command outstanding, actual %h", actual);
      errors++;
      return;
    end
    want = expected_pixels.pop_front();
    checked++;
    if (actual !== want) begin
      $error("read_pixel: expected %h, actual %h", want, actual);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected_pixels.size();
  endfunction

endclass

module tb_raster_fill_scroll_engine;
  import rfse_pkg::*;

  // Operation codes 5 to 7 are unused; the block must answer them with a zero word.
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // One command word as the testbench builds it.
  typedef struct packed {
    logic [2:0]         op;
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
    logic [COORD_W-1:0] rect_w;
    logic [COORD_W-1:0] rect_h;
    logic [PIXEL_W-1:0] color;
    logic [COORD_W-1:0] scroll_rows;
    logic [COORD_W-1:0] band_rows;
  } pixel_cmd_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               start;
  logic               busy;
  logic [2:0]         operation_i;
  logic [COORD_W-1:0] x_pos_i;
  logic [COORD_W-1:0] y_pos_i;
  logic [COORD_W-1:0] rect_width_i;
  logic [COORD_W-1:0] rect_height_i;
  logic [PIXEL_W-1:0] color_i;
  logic [COORD_W-1:0] scroll_rows_i;
  logic [COORD_W-1:0] band_rows_i;
  logic               read_valid_o;
  logic [PIXEL_W-1:0] read_pixel_o;

  raster_scoreboard sb = new();

  // Percentage of cycles in which the sender holds its next command back.
  int unsigned sender_idle_pct;
  int unsigned commands_sent;
  int unsigned geometries;
  // Recently written on-screen spots, packed as {x, y}, so that gets often read back
  // something a put just wrote.
  logic [2*COORD_W-1:0] put_spots [$];

  raster_fill_scroll_engine u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .color_i       (color_i),
    .scroll_rows_i (scroll_rows_i),
    .band_rows_i   (band_rows_i),
    .read_valid_o  (read_valid_o),
    .read_pixel_o  (read_pixel_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result words cannot be held off, so every strobe seen at a rising edge is checked
  // against the oldest expectation. Outputs are read at the edge, before the block's
  // own updates of that edge take effect.
  always @(posedge clk_i) begin
    if (rst_ni && read_valid_o) sb.check_pixel(read_pixel_o);
  end

  // Hard stop in case the block hangs: far above the slowest correct run, which is
  // dominated by the full-store clear at the default geometry.
  initial begin
    #40_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic pixel_cmd_t make_cmd(logic [2:0] op, int unsigned x, int unsigned y,
                                          int unsigned rect_w, int unsigned rect_h,
                                          logic [PIXEL_W-1:0] color,
                                          int unsigned count, int unsigned band);
    pixel_cmd_t c;
    c.op          = op;
    c.x_pos       = COORD_W'(x);
    c.y_pos       = COORD_W'(y);
    c.rect_w      = COORD_W'(rect_w);
    c.rect_h      = COORD_W'(rect_h);
    c.color       = color;
    c.scroll_rows = COORD_W'(count);
    c.band_rows   = COORD_W'(band);
    return c;
  endfunction

  // Random command shaped by the current geometry: coordinates and sizes mostly land
  // on or just past the display, with a share drawn from the full 10-bit range so
  // every field bit toggles. Gets often revisit a recent put.
  function automatic pixel_cmd_t random_cmd();
    pixel_cmd_t  c;
    int unsigned pick;
    int unsigned spot;
    c.color = $urandom;
    c.x_pos = ($urandom_range(4) == 0) ? COORD_W'($urandom)
                                       : COORD_W'($urandom_range(sb.disp_w, 0));
    c.y_pos = ($urandom_range(4) == 0) ? COORD_W'($urandom)
                                       : COORD_W'($urandom_range(sb.disp_h, 0));
    c.rect_w = ($urandom_range(3) == 0) ? COORD_W'($urandom)
                                        : COORD_W'($urandom_range(sb.disp_w, 0));
    c.rect_h = ($urandom_range(3) == 0) ? COORD_W'($urandom)
                                        : COORD_W'($urandom_range(sb.disp_h, 0));
    c.scroll_rows = ($urandom_range(4) < 2) ? COORD_W'($urandom)
                                            : COORD_W'($urandom_range(sb.disp_h, 0));
    c.band_rows = ($urandom_range(4) < 2) ? COORD_W'($urandom)
                                          : COORD_W'($urandom_range(sb.disp_h, 0));
    pick = $urandom_range(99);
    if (pick < 28) begin
      c.op = OP_PUT;
      if (c.x_pos < sb.disp_w && c.y_pos < sb.disp_h) begin
        put_spots.push_back({c.x_pos, c.y_pos});
        if (put_spots.size() > 8) void'(put_spots.pop_front());
      end
    end else if (pick < 58) begin
      c.op = OP_GET;
      if (put_spots.size() != 0 && $urandom_range(1) == 1) begin
        spot = $urandom_range(put_spots.size() - 1);
        {c.x_pos, c.y_pos} = put_spots[spot];
      end
    end else if (pick < 72) begin
      c.op = OP_FILL;
    end else if (pick < 84) begin
      c.op = OP_SCROLL;
    end else if (pick < 90) begin
      c.op = OP_CLEAR;
    end else begin
      c.op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    end
    return c;
  endfunction

  // Presents one command word and holds it until the block takes it, that is until a
  // rising edge finds start high and busy low. The expectation is noted right there.
  task automatic issue(input pixel_cmd_t c);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    operation_i   <= c.op;
    x_pos_i       <= c.x_pos;
    y_pos_i       <= c.y_pos;
    rect_width_i  <= c.rect_w;
    rect_height_i <= c.rect_h;
    color_i       <= c.color;
    scroll_rows_i <= c.scroll_rows;
    band_rows_i   <= c.band_rows;
    do @(posedge clk_i); while (busy);
    sb.note_command(c.op, c.x_pos, c.y_pos, c.rect_w, c.rect_h, c.color,
                    c.scroll_rows, c.band_rows);
    commands_sent++;
  endtask

  // Stops sending and waits for every outstanding result word.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // APB write with setup and access phases, then a read back of the same register.
  task automatic write_reg(input reg_idx_e idx, input int unsigned value);
    logic [PDATA_W-1:0] wdata;
    wdata   = PDATA_W'(value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, CFG_W'(value));
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== wdata) begin
      $error("prdata: expected %h, actual %h", wdata, prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    // Leave the bus idle, so the next access starts on a later edge.
    @(posedge clk_i);
  endtask

  // The geometry only changes once the block has gone quiet.
  task automatic set_geometry(input int unsigned w, input int unsigned h,
                              input int unsigned s);
    drain();
    write_reg(REG_DISPLAY_WIDTH, w);
    write_reg(REG_DISPLAY_HEIGHT, h);
    write_reg(REG_ROW_STRIDE, s);
    put_spots.delete();
    geometries++;
  endtask

  task automatic run_phase(input int unsigned w, input int unsigned h,
                           input int unsigned s, input int unsigned idle_pct,
                           input int unsigned items);
    set_geometry(w, h, s);
    sender_idle_pct = idle_pct;
    for (int unsigned i = 0; i < items; i++) begin
      issue(random_cmd());
      // Now and then the sender waits for the block to run dry before going on.
      if ($urandom_range(19) == 0) drain();
    end
    drain();
  endtask

  initial begin
    int unsigned spare;
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    start           <= 1'b0;
    operation_i     <= OP_PUT;
    x_pos_i         <= '0;
    y_pos_i         <= '0;
    rect_width_i    <= '0;
    rect_height_i   <= '0;
    color_i         <= '0;
    scroll_rows_i   <= '0;
    band_rows_i     <= '0;
    sender_idle_pct = 0;
    commands_sent   = 0;
    geometries      = 1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The store holds unknown data after reset. At the reset geometry of 256 x 256
    // with stride 256 a clear touches every word, so nothing read later is undefined.
    issue(make_cmd(OP_CLEAR, 0, 0, 0, 0, $urandom, 0, 0));

    // Corners of the default display, one step past its edges, and the field extremes.
    issue(make_cmd(OP_PUT, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0));
    issue(make_cmd(OP_PUT, 255, 255, 0, 0, 32'hA5A5_5A5A, 0, 0));
    issue(make_cmd(OP_GET, 255, 255, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_GET, 0, 0, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_PUT, 256, 0, 0, 0, 32'h1234_5678, 0, 0));
    issue(make_cmd(OP_GET, 256, 0, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_GET, 0, 1023, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_GET, 1023, 1023, 1023, 1023, 32'hFFFF_FFFF, 1023, 1023));
    // A rectangle hanging off the bottom right corner is clipped to 6 x 4 pixels.
    issue(make_cmd(OP_FILL, 250, 252, 1023, 1023, 32'h0000_0000, 0, 0));
    issue(make_cmd(OP_GET, 255, 255, 0, 0, 0, 0, 0));
    // An empty rectangle writes nothing.
    issue(make_cmd(OP_FILL, 10, 10, 0, 5, 32'hDEAD_BEEF, 0, 0));
    issue(make_cmd(OP_GET, 10, 10, 0, 0, 0, 0, 0));
    for (spare = OP_SPARE_LO; spare <= OP_SPARE_HI; spare++)
      issue(make_cmd(3'(spare), 1, 1, 1, 1, $urandom, 1, 1));

    // Small geometry with a stride wider than the display for the scroll cases.
    set_geometry(8, 6, 11);
    issue(make_cmd(OP_FILL, 1, 1, 3, 2, 32'h00FF_00FF, 0, 0));
    issue(make_cmd(OP_SCROLL, 0, 0, 0, 0, 32'h1111_1111, 2, 1));
    issue(make_cmd(OP_GET, 1, 0, 0, 0, 0, 0, 0));
    // Scrolling by zero rows copies the display onto itself.
    issue(make_cmd(OP_SCROLL, 0, 0, 0, 0, 32'h2222_2222, 0, 0));
    // A count equal to the height, or far above it, clears the display instead.
    issue(make_cmd(OP_SCROLL, 0, 0, 0, 0, 32'h3333_3333, 6, 2));
    issue(make_cmd(OP_PUT, 7, 5, 0, 0, 32'h4444_4444, 0, 0));
    issue(make_cmd(OP_SCROLL, 0, 0, 0, 0, 32'h5555_5555, 1023, 0));
    // A band taller than the display saturates to the top row.
    issue(make_cmd(OP_SCROLL, 0, 0, 0, 0, 32'h6666_6666, 1, 1023));
    issue(make_cmd(OP_GET, 7, 0, 0, 0, 0, 0, 0));
    drain();

    // Random phases over several geometries, down to 1 x 1 and up to the full width
    // and height, including a stride narrower than the display. Sender gaps vary.
    run_phase(8, 6, 11, 0, 13);
    run_phase(16, 12, 16, 70, 13);
    run_phase(1, 1, 1, 9, 13);
    run_phase(256, 4, 256, 0, 13);
    run_phase(5, 256, 3, 70, 12);
    run_phase(20, 9, 256, 9, 12);

    // Give a stray result word time to show up after the last expected one.
    repeat (20) @(posedge clk_i);
    $display("Covered %0d commands over %0d display geometries, %0d result words checked.",
             commands_sent, geometries, sb.checked);
    $display("Put, get, fill, scroll, clear and unused codes ran with 0, 9 and 70%% gaps.");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/rfse_pkg.sv
sv/rfse_front.sv
sv/rfse_cmd_queue.sv
sv/rfse_back.sv
sv/raster_fill_scroll_engine.sv
sv/rfse_checker.sv
tb/tb_raster_fill_scroll_engine.sv
